// ===== rtl/register_allocation_map_assert.svh =====
// Assertion macros for the register allocation map top level.
`ifndef REGISTER_ALLOCATION_MAP_ASSERT_SVH
`define REGISTER_ALLOCATION_MAP_ASSERT_SVH

// Checked only while out of reset.
`define RMAP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked on every edge, reset included.
`define RMAP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== rtl/rmap_pkg.sv =====
// Package for the register allocation map: transfer types, codes and the pool table.
`default_nettype none

package rmap_pkg;

    // Operand kinds
    localparam logic [1:0] KindUse     = 2'd0;
    localparam logic [1:0] KindDefine  = 2'd1;
    localparam logic [1:0] KindEnd     = 2'd2;
    localparam logic [1:0] KindIgnored = 2'd3;   // passes through untouched

    // Result error codes
    localparam logic [2:0] ErrOk             = 3'd0;
    localparam logic [2:0] ErrNotAlloc       = 3'd1;
    localparam logic [2:0] ErrNotAllocatable = 3'd2;
    localparam logic [2:0] ErrRemap          = 3'd3;
    localparam logic [2:0] ErrNoFree         = 3'd4;
    localparam logic [2:0] ErrLive           = 3'd5;

    localparam logic [3:0] NoSlot  = 4'd15;
    localparam int         PoolMax = 31;
    localparam int         PoolIdxW = 5;

    // ABI x-register numbers at the pool's anchor points
    localparam logic [4:0] RvA0 = 5'd10;
    localparam logic [4:0] RvA7 = 5'd17;
    localparam logic [4:0] RvT0 = 5'd5;
    localparam logic [4:0] RvT6 = 5'd31;

    typedef struct packed {
        logic [1:0]  kind;
        logic        is_virtual;
        logic [15:0] reg_number;
        logic        last_use;
    } rmap_in_t;

    typedef struct packed {
        logic [15:0] mapped_reg;
        logic [3:0]  slot;
        logic [2:0]  error;
    } rmap_out_t;

    // Match results of one lookup pass over the slots; lowest slot wins.
    typedef struct packed {
        logic                free_hit;
        logic [PoolIdxW-1:0] free_idx;
        logic                virt_hit;
        logic [PoolIdxW-1:0] virt_idx;
        logic                phys_hit;
        logic [PoolIdxW-1:0] phys_idx;
        logic                phys_busy;
        logic                live_hit;
        logic [PoolIdxW-1:0] live_idx;
    } rmap_search_t;

    // Slot -> x-register: a0-a7, t0-t6, then s2-s11, s1, s0, x1..x4.
    function automatic logic [4:0] pool_xreg(input logic [PoolIdxW-1:0] idx);
        logic [4:0] x;
        case (idx)
            5'd0:  x = RvA0;   5'd1:  x = 5'd11;  5'd2:  x = 5'd12;  5'd3:  x = 5'd13;
            5'd4:  x = 5'd14;  5'd5:  x = 5'd15;  5'd6:  x = 5'd16;  5'd7:  x = RvA7;
            5'd8:  x = RvT0;   5'd9:  x = 5'd6;   5'd10: x = 5'd7;   5'd11: x = 5'd28;
            5'd12: x = 5'd29;  5'd13: x = 5'd30;  5'd14: x = RvT6;   5'd15: x = 5'd18;
            5'd16: x = 5'd19;  5'd17: x = 5'd20;  5'd18: x = 5'd21;  5'd19: x = 5'd22;
            5'd20: x = 5'd23;  5'd21: x = 5'd24;  5'd22: x = 5'd25;  5'd23: x = 5'd26;
            5'd24: x = 5'd27;  5'd25: x = 5'd9;   5'd26: x = 5'd8;   5'd27: x = 5'd1;
            5'd28: x = 5'd2;   5'd29: x = 5'd3;   5'd30: x = 5'd4;
            default: x = 5'd0;
        endcase
        return x;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/rmap_search.sv =====
// Parallel slot lookup: first free, virtual owner, physical slot, first live.
`default_nettype none

module rmap_search #(
    parameter int NUM_SLOTS = 15,
    parameter int VREG_BITS = 16
) (
    input  wire logic [NUM_SLOTS-1:0] owner_valid,
    input  wire logic [NUM_SLOTS-1:0] owner_virt,
    input  wire logic [VREG_BITS-1:0] owner_num [NUM_SLOTS],
    input  wire logic [VREG_BITS-1:0] vnum,
    input  wire logic [15:0]          reg_number,
    output rmap_pkg::rmap_search_t    found
);
    import rmap_pkg::*;

    logic phys_range;

    assign phys_range = (reg_number[15:5] == '0);

    // Walk high to low so the lowest matching slot is left standing.
    always_comb begin
        found = '0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!owner_valid[i]) begin
                found.free_hit = 1'b1;
                found.free_idx = PoolIdxW'(i);
            end
            if (owner_valid[i] && owner_virt[i] && owner_num[i] == vnum) begin
                found.virt_hit = 1'b1;
                found.virt_idx = PoolIdxW'(i);
            end
            if (phys_range && pool_xreg(PoolIdxW'(i)) == reg_number[4:0]) begin
                found.phys_hit  = 1'b1;
                found.phys_idx  = PoolIdxW'(i);
                found.phys_busy = owner_valid[i];
            end
            if (owner_valid[i]) begin
                found.live_hit = 1'b1;
                found.live_idx = PoolIdxW'(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/register_allocation_map.sv =====
// Register allocation map top level: operand pipeline, slot owner state, result register.
//
// Local register allocator over a pool of NUM_SLOTS physical registers (a0-a7, t0-t6 by
// default). Each s_ transfer is one operand: a use rewrites a virtual register to the
// physical register that owns it (kill frees it), a define takes the lowest free slot or
// claims a named physical slot (a dead flag frees the lowest slot it then owns), and a
// block end reports the lowest still-owned slot and clears the pool. Each operand yields
// exactly one m_ transfer. Throughput is one operand per cycle while m_ready is high. The
// whole lookup (free-slot priority encoder, virtual owner match, physical slot match)
// plus the state update sits between the operand register and the result register, and
// the owner state is updated as an operand leaves the operand register, so the next
// operand always sees it. Slot valid bits reset to free at once; there is no clearing
// pass. An operand that reports an error (other than live at block end) changes no
// state. s_ready drops only when both registers are full and m_ready is low.
`default_nettype none

module register_allocation_map #(
    parameter int NUM_SLOTS = 15,
    parameter int VREG_BITS = 16
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire rmap_pkg::rmap_in_t  s_payload,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output rmap_pkg::rmap_out_t      m_payload
);
    import rmap_pkg::*;

`include "register_allocation_map_assert.svh"

    localparam int IdxW  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int KeepW = (VREG_BITS < 16) ? VREG_BITS : 16;

    // Pipeline registers
    logic      in_valid_reg, in_valid_next;
    rmap_in_t  in_reg;
    logic      out_valid_reg, out_valid_next;
    rmap_out_t out_reg;
    logic      advance;

    // Slot owner state
    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [NUM_SLOTS-1:0] virt_reg;
    logic [VREG_BITS-1:0] num_reg [NUM_SLOTS];

    // Lookup and decision
    logic [VREG_BITS-1:0] vnum;
    rmap_search_t         found;
    rmap_out_t            res;
    logic                 skip;
    logic                 clr_all;
    logic                 set_en, set_virt;
    logic                 clr_en;
    logic [PoolIdxW-1:0]  set_idx, clr_idx;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_payload = out_reg;

    assign vnum = VREG_BITS'(in_reg.reg_number[KeepW-1:0]);

    rmap_search #(
        .NUM_SLOTS (NUM_SLOTS),
        .VREG_BITS (VREG_BITS)
    ) u_search (
        .owner_valid (valid_reg),
        .owner_virt  (virt_reg),
        .owner_num   (num_reg),
        .vnum        (vnum),
        .reg_number  (in_reg.reg_number),
        .found       (found)
    );

    // Physical ids above x31 and the unused kind pass through untouched.
    assign skip = (in_reg.kind == KindIgnored)
               || (!in_reg.is_virtual && in_reg.reg_number[15:5] != '0);

    always_comb begin
        res      = '{mapped_reg: in_reg.reg_number, slot: NoSlot, error: ErrOk};
        clr_all  = 1'b0;
        set_en   = 1'b0;
        set_virt = 1'b0;
        set_idx  = found.free_idx;
        clr_en   = 1'b0;
        clr_idx  = found.virt_idx;
        priority if (in_reg.kind == KindEnd) begin
            res.mapped_reg = '0;
            clr_all        = 1'b1;
            if (found.live_hit) begin
                res.slot  = found.live_idx[3:0];
                res.error = ErrLive;
            end
        end else if (skip) begin
            // pass-through, defaults hold
        end else if (in_reg.kind == KindUse) begin
            if (in_reg.is_virtual) begin
                if (!found.virt_hit) begin
                    res.error = ErrNotAlloc;
                end else begin
                    res.mapped_reg = 16'(pool_xreg(found.virt_idx));
                    res.slot       = found.virt_idx[3:0];
                    clr_en         = in_reg.last_use;
                end
            end else begin
                clr_idx = found.phys_idx;
                priority if (in_reg.last_use && !found.phys_hit) begin
                    res.error = ErrNotAllocatable;
                end else if (in_reg.last_use && !found.phys_busy) begin
                    res.error = ErrNotAlloc;
                end else if (found.phys_hit) begin
                    res.mapped_reg = 16'(pool_xreg(found.phys_idx));
                    res.slot       = found.phys_idx[3:0];
                    clr_en         = in_reg.last_use;
                end else begin
                    // physical register outside the pool, no kill: passes through
                end
            end
        end else begin
            // define
            if (in_reg.is_virtual) begin
                if (!found.free_hit) begin
                    res.error = ErrNoFree;
                end else begin
                    res.mapped_reg = 16'(pool_xreg(found.free_idx));
                    res.slot       = found.free_idx[3:0];
                    set_virt       = 1'b1;
                    // dead define frees the lowest slot owned by this virtual,
                    // which is the new slot itself unless an older one sits lower
                    if (!in_reg.last_use) begin
                        set_en = 1'b1;
                    end else if (found.virt_hit && found.virt_idx < found.free_idx) begin
                        set_en = 1'b1;
                        clr_en = 1'b1;
                    end
                end
            end else begin
                set_idx = found.phys_idx;
                priority if (!found.phys_hit) begin
                    res.error = ErrNotAllocatable;
                end else if (found.phys_busy) begin
                    res.error = ErrRemap;
                end else begin
                    res.mapped_reg = 16'(pool_xreg(found.phys_idx));
                    res.slot       = found.phys_idx[3:0];
                    set_en         = !in_reg.last_use;
                end
            end
        end
    end

    // Owner valid bits
    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            if (clr_all) begin
                valid_next = '0;
            end else begin
                if (set_en) begin
                    valid_next[set_idx[IdxW-1:0]] = 1'b1;
                end
                if (clr_en) begin
                    valid_next[clr_idx[IdxW-1:0]] = 1'b0;
                end
            end
        end
    end

    // Handshake control
    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
        end
    end

    // Payload registers, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_payload;
        end
        if (advance) begin
            out_reg <= res;
        end
        if (advance && !clr_all && set_en) begin
            virt_reg[set_idx[IdxW-1:0]] <= set_virt;
            num_reg[set_idx[IdxW-1:0]]  <= vnum;
        end
    end

    // Checks
    `RMAP_ASSERT(a_end_clears, advance && in_reg.kind == KindEnd |=> valid_reg == '0, "block end left a slot owned")
    `RMAP_ASSERT(a_end_result, advance && in_reg.kind == KindEnd |=> m_valid && m_payload.mapped_reg == '0, "block end result not shown")
    `RMAP_ASSERT(a_err_no_change, advance && in_reg.kind != KindEnd && res.error != ErrOk |=> $stable(valid_reg), "error step changed slot state")
    `RMAP_ASSERT(a_set_clr_apart, advance && set_en && clr_en |-> set_idx != clr_idx, "same slot set and freed")
    `RMAP_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> !m_valid && valid_reg == '0, "reset left state behind")

endmodule

`default_nettype wire

// ===== test/tb_register_allocation_map.sv =====
// Self-checking testbench for the register allocation map: slot ownership, mapping and errors.
`default_nettype none

module tb_register_allocation_map;
    import rmap_pkg::*;

    localparam int SLOTS       = 15;       // default pool: a0-a7, t0-t6
    localparam int CYCLE_LIMIT = 200000;   // ~800 operands with idling, many times over
    localparam int DRAIN_CYCLES = 4;       // two-stage pipeline plus margin

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    rmap_in_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    rmap_out_t m_payload;

    register_allocation_map uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Predicted pool state: one owner per slot (valid, virtual flag, number)
    // ------------------------------------------------------------------
    logic        own_valid [SLOTS];
    logic        own_virt  [SLOTS];
    logic [15:0] own_num   [SLOTS];

    rmap_out_t pending_mappings [$];   // predicted results, oldest first

    int operands_sent   = 0;
    int mappings_checked = 0;
    int mismatches      = 0;
    int cycle_count     = 0;
    int codes_seen [8];

    logic stalls_on  = 1'b0;   // random idling on both channels
    int   stall_left = 0;
    rmap_out_t want;

    // x-register behind each pool slot
    function automatic logic [4:0] slot_to_xreg(int s);
        case (s)
            0:  return RvA0;
            1:  return 5'd11;
            2:  return 5'd12;
            3:  return 5'd13;
            4:  return 5'd14;
            5:  return 5'd15;
            6:  return 5'd16;
            7:  return RvA7;
            8:  return RvT0;
            9:  return 5'd6;
            10: return 5'd7;
            11: return 5'd28;
            12: return 5'd29;
            13: return 5'd30;
            14: return RvT6;
            default: return 5'd0;
        endcase
    endfunction

    function automatic int phys_slot(logic [15:0] r);
        int i;
        for (i = 0; i < SLOTS; i++)
            if (r == {11'd0, slot_to_xreg(i)}) return i;
        return -1;
    endfunction

    // lowest slot owned by virtual v
    function automatic int virt_slot(logic [15:0] v);
        int i;
        for (i = 0; i < SLOTS; i++)
            if (own_valid[i] && own_virt[i] && own_num[i] == v) return i;
        return -1;
    endfunction

    function automatic void clear_slots();
        int i;
        for (i = 0; i < SLOTS; i++) begin
            own_valid[i] = 1'b0;
            own_virt[i]  = 1'b0;
            own_num[i]   = '0;
        end
    endfunction

    function automatic void free_slot(int s);
        own_valid[s] = 1'b0;
        own_virt[s]  = 1'b0;
        own_num[s]   = '0;
    endfunction

    // Expected result of one operand; updates the predicted pool.
    // Any error result other than live at block end leaves the pool as it was.
    function automatic rmap_out_t predict_mapping(rmap_in_t op);
        rmap_out_t r;
        int s;
        int i;
        r.mapped_reg = op.reg_number;
        r.slot       = NoSlot;
        r.error      = ErrOk;

        if (op.kind == KindEnd) begin
            // report lowest live slot, then wipe the pool
            r.mapped_reg = '0;
            for (i = SLOTS - 1; i >= 0; i--)
                if (own_valid[i]) begin
                    r.slot  = 4'(i);
                    r.error = ErrLive;
                end
            clear_slots();
            return r;
        end
        // ignored kind, or a physical id that is no register at all
        if (op.kind == KindIgnored || (!op.is_virtual && op.reg_number > 16'd31))
            return r;

        if (op.kind == KindUse) begin
            if (op.is_virtual) begin
                s = virt_slot(op.reg_number);
                if (s < 0) begin
                    r.error = ErrNotAlloc;
                    return r;
                end
            end else begin
                s = phys_slot(op.reg_number);
                if (op.last_use && s < 0) begin
                    r.error = ErrNotAllocatable;
                    return r;
                end
                if (op.last_use && !own_valid[s]) begin
                    r.error = ErrNotAlloc;
                    return r;
                end
                // physical use without kill: no ownership check
                if (s < 0) return r;
            end
            if (op.last_use) free_slot(s);
        end else if (op.is_virtual) begin
            // define virtual: lowest free slot, even if it already owns one
            s = -1;
            for (i = SLOTS - 1; i >= 0; i--)
                if (!own_valid[i]) s = i;
            if (s < 0) begin
                r.error = ErrNoFree;
                return r;
            end
            own_valid[s] = 1'b1;
            own_virt[s]  = 1'b1;
            own_num[s]   = op.reg_number;
            // dead define frees the lowest slot of that virtual, maybe an older one
            if (op.last_use) free_slot(virt_slot(op.reg_number));
        end else begin
            s = phys_slot(op.reg_number);
            if (s < 0) begin
                r.error = ErrNotAllocatable;
                return r;
            end
            if (own_valid[s]) begin
                r.error = ErrRemap;
                return r;
            end
            own_valid[s] = !op.last_use;
            own_virt[s]  = 1'b0;
            own_num[s]   = op.last_use ? 16'd0 : op.reg_number;
        end
        r.mapped_reg = {11'd0, slot_to_xreg(s)};
        r.slot       = 4'(s);
        return r;
    endfunction

    function automatic rmap_in_t operand(logic [1:0] kind, logic virt, logic [15:0] r,
                                         logic last);
        rmap_in_t op;
        op.kind       = kind;
        op.is_virtual = virt;
        op.reg_number = r;
        op.last_use   = last;
        return op;
    endfunction

    // Random operand shaped like a basic block: mostly defines and uses of
    // virtuals that are live, some physical traffic, some raw noise.
    function automatic rmap_in_t block_operand(int end_pct);
        rmap_in_t op;
        logic [15:0] live [$];
        logic [31:0] raw;
        int i;
        int pick;
        for (i = 0; i < SLOTS; i++)
            if (own_valid[i] && own_virt[i]) live.push_back(own_num[i]);
        op = operand(KindUse, 1'b1, 16'd0, $urandom_range(0, 3) == 0);
        pick = $urandom_range(0, 99);
        if (pick < end_pct) begin
            op.kind = KindEnd;
            op.reg_number = 16'($urandom_range(0, 65535));
        end else if (pick < 12) begin
            raw = $urandom;
            op = raw[19:0];
        end else if (pick < 40) begin
            op.kind = KindDefine;
            op.reg_number = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                                        : 16'($urandom_range(0, 15));
            op.last_use = $urandom_range(0, 7) == 0;
        end else if (pick < 75 && live.size() > 0) begin
            op.reg_number = live[$urandom_range(0, live.size() - 1)];
        end else if (pick < 88) begin
            op.kind = $urandom_range(0, 1) ? KindDefine : KindUse;
            op.is_virtual = 1'b0;
            op.reg_number = 16'($urandom_range(0, 33));
        end else begin
            op.reg_number = 16'($urandom_range(0, 15));   // may well be unallocated
        end
        return op;
    endfunction

    // ------------------------------------------------------------------
    // Input side: one transfer per call, predicted on acceptance.
    // Called and returns at a falling edge; valid stays up between calls.
    // ------------------------------------------------------------------
    task automatic send_operand(rmap_in_t op);
        rmap_out_t prediction;
        if (stalls_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge aclk);
        end
        s_payload <= op;
        s_valid   <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        prediction = predict_mapping(op);
        pending_mappings.push_back(prediction);
        codes_seen[prediction.error]++;
        operands_sent++;
        @(negedge aclk);
    endtask

    // Let every outstanding result arrive, then idle for a drain margin.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        while (pending_mappings.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // ------------------------------------------------------------------
    // Output side: random m_ready stall bursts while enabled
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!stalls_on) begin
            stall_left = 0;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 8);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Result checker: each transfer against the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_mappings.size() == 0) begin
                $display("%0t: unexpected result: actual reg %0d slot %0d err %0d",
                         $time, m_payload.mapped_reg, m_payload.slot, m_payload.error);
                mismatches++;
            end else begin
                want = pending_mappings.pop_front();
                mappings_checked++;
                if (m_payload.mapped_reg !== want.mapped_reg) begin
                    $display("%0t: mapped_reg mismatch: expected %0d, actual %0d",
                             $time, want.mapped_reg, m_payload.mapped_reg);
                    mismatches++;
                end
                if (m_payload.slot !== want.slot) begin
                    $display("%0t: slot mismatch: expected %0d, actual %0d",
                             $time, want.slot, m_payload.slot);
                    mismatches++;
                end
                if (m_payload.error !== want.error) begin
                    $display("%0t: error mismatch: expected %0d, actual %0d",
                             $time, want.error, m_payload.error);
                    mismatches++;
                end
            end
        end
    end

    // Hard stop in case the handshake hangs
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still outstanding", $time,
                     pending_mappings.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corner cases walked through one by one: empty pool, passthroughs,
    // duplicate and dead defines, remap, kills and block end with live slots.
    task automatic test_directed_cases();
        stalls_on = 1'b0;
        send_operand(operand(KindEnd,     1'b0, 16'd0,     1'b0)); // end on empty pool
        send_operand(operand(KindUse,     1'b0, 16'd0,     1'b0)); // x0 not in pool, no check
        send_operand(operand(KindUse,     1'b0, 16'd0,     1'b1)); // kill x0: not allocatable
        send_operand(operand(KindDefine,  1'b0, 16'd0,     1'b0)); // define x0: not allocatable
        send_operand(operand(KindUse,     1'b0, 16'hFFFF,  1'b1)); // id above 31 passes
        send_operand(operand(KindDefine,  1'b0, 16'd32,    1'b0));
        send_operand(operand(KindIgnored, 1'b1, 16'hABCD,  1'b1));
        send_operand(operand(KindUse,     1'b1, 16'd0,     1'b0)); // virtual never defined
        send_operand(operand(KindDefine,  1'b1, 16'd0,     1'b0)); // -> slot 0
        send_operand(operand(KindDefine,  1'b1, 16'hFFFF,  1'b0)); // -> slot 1
        send_operand(operand(KindUse,     1'b1, 16'hFFFF,  1'b0));
        send_operand(operand(KindDefine,  1'b1, 16'd0,     1'b0)); // second slot for v0
        send_operand(operand(KindDefine,  1'b1, 16'd0,     1'b1)); // dead: frees slot 0
        send_operand(operand(KindUse,     1'b1, 16'd0,     1'b0)); // now slot 2
        send_operand(operand(KindDefine,  1'b0, 16'd10,    1'b0)); // claim a0
        send_operand(operand(KindDefine,  1'b0, 16'd10,    1'b0)); // remap conflict
        send_operand(operand(KindDefine,  1'b0, 16'd31,    1'b1)); // dead t6 stays free
        send_operand(operand(KindDefine,  1'b0, 16'd31,    1'b0));
        send_operand(operand(KindUse,     1'b0, 16'd31,    1'b0));
        send_operand(operand(KindUse,     1'b0, 16'd5,     1'b0)); // free pool reg, no kill
        send_operand(operand(KindUse,     1'b0, 16'd11,    1'b1)); // kill via physical name
        send_operand(operand(KindUse,     1'b0, 16'd11,    1'b1)); // already free
        send_operand(operand(KindUse,     1'b1, 16'd0,     1'b1)); // kill v0 in slot 2
        send_operand(operand(KindUse,     1'b1, 16'd0,     1'b0)); // v0 still in slot 3
        send_operand(operand(KindEnd,     1'b1, 16'h5555,  1'b1)); // live at block end
        send_operand(operand(KindEnd,     1'b0, 16'd0,     1'b0)); // clean after clear
        wait_for_results();
    endtask

    // Fill the pool with random virtuals until it runs dry, collide a
    // physical define with it, free a few and close the block.
    task automatic test_pool_exhaustion();
        int round;
        int n;
        stalls_on = 1'b1;
        for (round = 0; round < 4; round++) begin
            for (n = 0; n < 18; n++)
                send_operand(operand(KindDefine, 1'b1, 16'($urandom_range(0, 65535)),
                                     $urandom_range(0, 9) == 0));
            send_operand(operand(KindDefine, 1'b0, {11'd0, slot_to_xreg($urandom_range(0, 14))},
                                 1'b0));
            for (n = 0; n < 6; n++)
                send_operand(block_operand(0));
            send_operand(operand(KindEnd, 1'b0, 16'($urandom_range(0, 65535)), 1'b0));
        end
        wait_for_results();
    endtask

    // Long random blocks, idling switched on and off in stretches
    task automatic test_random_blocks();
        int chunk;
        int n;
        for (chunk = 0; chunk < 8; chunk++) begin
            stalls_on = $urandom_range(0, 3) != 0;
            for (n = 0; n < 60; n++)
                send_operand(block_operand(3));
        end
        wait_for_results();
    endtask

    // Back-to-back transfers with both sides always ready
    task automatic test_full_rate();
        int n;
        stalls_on = 1'b0;
        for (n = 0; n < 130; n++)
            send_operand(block_operand(3));
        wait_for_results();
    endtask

    initial begin
        clear_slots();
        foreach (codes_seen[i]) codes_seen[i] = 0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_cases();
        test_pool_exhaustion();
        test_random_blocks();
        test_full_rate();

        $display("Covered %0d operands, %0d results checked, %0d mismatches",
                 operands_sent, mappings_checked, mismatches);
        $display("By code: ok %0d, not alloc %0d, bad reg %0d, remap %0d, no free %0d, live %0d",
                 codes_seen[ErrOk], codes_seen[ErrNotAlloc], codes_seen[ErrNotAllocatable],
                 codes_seen[ErrRemap], codes_seen[ErrNoFree], codes_seen[ErrLive]);
        if (mismatches == 0 && pending_mappings.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
